### hdl/wffap_pkg.sv
// Package with the shared widths, constants and types of the AP-learning frame filter.
package wffap_pkg;

   localparam int ADDR_W     = 48;
   localparam int TYPE_W     = 2;
   localparam int SUBTYPE_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [TYPE_W-1:0]    BEACON_TYPE    = 2'd0;
   localparam logic [SUBTYPE_W-1:0] BEACON_SUBTYPE = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_DROP_KNOWN_AP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_MASK_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_MASK_HIGH = 2'd2;

   localparam logic [CSR_DATA_W-1:0] TYPE_MASK_RESET = 32'hFFFF_FFFF;

   typedef logic [ADDR_W-1:0] addr_type;

   // Signals handed from one table cell to the next.
   typedef struct packed {
      logic hit;     // some earlier cell matched the key
      logic filled;  // this cell and all earlier cells hold an address
   } link_type;

   typedef enum logic {
      ST_IDLE,
      ST_MATCH
   } state_type;

endpackage

### hdl/wffap_req_if.sv
// Request channel interface: one frame header per beat.
interface wffap_req_if;
   logic                                valid;
   logic                                ready;
   logic [wffap_pkg::TYPE_W-1:0]        frame_type;
   logic [wffap_pkg::SUBTYPE_W-1:0]     frame_subtype;
   logic [wffap_pkg::ADDR_W-1:0]        source_address;

   modport source (output valid, output frame_type, output frame_subtype,
                   output source_address, input ready);
   modport sink   (input valid, input frame_type, input frame_subtype,
                   input source_address, output ready);
endinterface

### hdl/wffap_rsp_if.sv
// Response channel interface: one filter verdict per beat.
interface wffap_rsp_if;
   logic valid;
   logic ready;
   logic accept;
   logic known_source;
   logic learned;
   logic table_full;

   modport source (output valid, output accept, output known_source,
                   output learned, output table_full, input ready);
   modport sink   (input valid, input accept, input known_source,
                   input learned, input table_full, output ready);
endinterface

### hdl/wffap_cell.sv
// One entry of the learned-address table, with its compare and fill logic.
module wffap_cell (
   input  logic                clock,
   input  logic                reset,
   input  wffap_pkg::addr_type key,
   input  logic                write_en,
   input  wffap_pkg::link_type link_in,
   output wffap_pkg::link_type link_out
);
   import wffap_pkg::*;

   addr_type entry_ff;
   logic     valid_ff;
   logic     claim;

   // The first empty cell after a run of filled ones takes a new address.
   assign claim = link_in.filled && !valid_ff;

   assign link_out.hit    = link_in.hit || (valid_ff && (entry_ff == key));
   assign link_out.filled = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (write_en && claim) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en && claim) begin
         entry_ff <= key;
      end
   end

endmodule

### hdl/wifi_frame_filter_ap_learning_unit.sv
// Top level of the AP-learning frame filter: header register, table cell row and verdict logic.
//
// Each request beat carries one 802.11 header (type, subtype, source address)
// and yields exactly one response beat. The source is compared against a row of
// TABLE_DEPTH cells, each holding one learned access-point address; the hit
// signal ripples from cell to cell. A beacon (type 0, subtype 8) from an unknown
// source is written into the first empty cell; when every cell is filled the
// beacon is flagged table_full instead. With drop_known_ap set, frames from known
// sources and unknown beacons are rejected; all other frames are judged by the
// 64-bit type mask at bit type*16+subtype. The header is captured first; then, in the
// match state, the compare runs along the cell row, the table is updated and the
// response register is loaded. A new header is taken only once the match state is left,
// which stalls while the response register stays full. The response register lets the next
// header be captured while an earlier verdict still waits. The table resets
// empty at once through per-cell valid bits; no clearing pass is needed.
// Configuration writes are accepted in any cycle and take effect immediately.
module wifi_frame_filter_ap_learning_unit #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   wffap_req_if.sink                            req,
   wffap_rsp_if.source                          rsp,
   input  logic                                 csr_write_enable,
   input  logic [wffap_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wffap_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import wffap_pkg::*;

   // Configuration registers.
   logic                  drop_known_ap_ff;
   logic [CSR_DATA_W-1:0] type_mask_low_ff;
   logic [CSR_DATA_W-1:0] type_mask_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_known_ap_ff  <= 1'b0;
         type_mask_low_ff  <= TYPE_MASK_RESET;
         type_mask_high_ff <= TYPE_MASK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DROP_KNOWN_AP:  drop_known_ap_ff  <= csr_write_data[0];
            CSR_TYPE_MASK_LOW:  type_mask_low_ff  <= csr_write_data;
            CSR_TYPE_MASK_HIGH: type_mask_high_ff <= csr_write_data;
            default: ;  // Writes beyond the register list are ignored.
         endcase
      end
   end

   // Control state machine.
   state_type state_ff;
   state_type state_in;
   logic      advance;
   logic      req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      advance   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         // The verdict leaves the match stage only when the response register
         // is empty or is being emptied in this cycle.
         ST_MATCH: advance = !rsp.valid || rsp.ready;
         default: ;
      endcase
   end

   assign req.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Captured header.
   logic [TYPE_W-1:0]    frame_type_ff;
   logic [SUBTYPE_W-1:0] frame_subtype_ff;
   addr_type             source_address_ff;

   always_ff @(posedge clock) begin
      if (req.valid && req_ready) begin
         frame_type_ff     <= req.frame_type;
         frame_subtype_ff  <= req.frame_subtype;
         source_address_ff <= req.source_address;
      end
   end

   // Row of table cells. Cell 0 sees no earlier hit and a filled predecessor,
   // so it is the first to take an address.
   link_type links [TABLE_DEPTH+1];
   logic     learn_write;

   assign links[0] = '{hit: 1'b0, filled: 1'b1};

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      wffap_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .key      (source_address_ff),
         .write_en (learn_write),
         .link_in  (links[i]),
         .link_out (links[i+1])
      );
   end

   // Verdict for the captured header.
   logic       known;
   logic       full;
   logic       beacon;
   logic       learn_try;
   logic       drop;
   logic [4:0] mask_pos;
   logic       mask_bit;
   logic       accept_in;

   assign known     = links[TABLE_DEPTH].hit;
   assign full      = links[TABLE_DEPTH].filled;
   assign beacon    = (frame_type_ff == BEACON_TYPE) && (frame_subtype_ff == BEACON_SUBTYPE);
   assign learn_try = !known && beacon;
   assign drop      = drop_known_ap_ff && (known || learn_try);

   // Types 0 and 1 index the low word, types 2 and 3 the high word.
   assign mask_pos  = {frame_type_ff[0], frame_subtype_ff};
   assign mask_bit  = frame_type_ff[1] ? type_mask_high_ff[mask_pos]
                                       : type_mask_low_ff[mask_pos];
   assign accept_in = !drop && mask_bit;

   assign learn_write = advance && learn_try && !full;

   // Response register.
   logic rsp_valid_ff;
   logic accept_ff;
   logic known_source_ff;
   logic learned_ff;
   logic table_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         accept_ff       <= accept_in;
         known_source_ff <= known;
         learned_ff      <= learn_try && !full;
         table_full_ff   <= learn_try && full;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.accept       = accept_ff;
   assign rsp.known_source = known_source_ff;
   assign rsp.learned      = learned_ff;
   assign rsp.table_full   = table_full_ff;

endmodule

### tb/wifi_frame_filter_ap_learning_unit_tb.sv
// Self-checking testbench for the AP-learning frame filter with a built-in verdict predictor.
`timescale 1ns / 1ps

module wifi_frame_filter_ap_learning_unit_tb;
   import wffap_pkg::*;

   // The table depth used by both the block and the predictor.
   localparam int DEPTH = 32;
   // Register index 3 exists on the port but names no register; writes to it are ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   // Even in the phases where one side stalls 81% of the time, a full run stays far
   // below this many cycles.
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 250;

   // One verdict beat, as seen on the response channel.
   typedef struct packed {
      logic accept;
      logic known_source;
      logic learned;
      logic table_full;
   } verdict_type;

   logic clock;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   wffap_req_if req_if ();
   wffap_rsp_if rsp_if ();

   wifi_frame_filter_ap_learning_unit #(
      .TABLE_DEPTH (DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state: a private copy of the learned AP table and of the registers.
   addr_type    learned_aps [DEPTH];
   int          learned_count;
   logic        drop_known;
   logic [63:0] type_mask;

   // Verdicts predicted for accepted headers, oldest first.
   verdict_type pending_verdicts [$];

   // Idle percentages of the two sides; the sender reads its value before each header, the response side every cycle.
   int send_idle_pct;
   int rsp_stall_pct;

   int errors;
   int cycles;
   int n_headers;
   int n_verdicts;
   int n_accepted;
   int n_known;
   int n_learned;
   int n_full;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Works out the verdict for one header and updates the predicted table. A known
   // source is dropped when the drop option is set and otherwise judged by the mask.
   // An unknown beacon is appended while there is room, else it raises table_full;
   // either way the drop option rejects it.
   function automatic verdict_type predict_verdict(logic [TYPE_W-1:0] ftype,
                                                   logic [SUBTYPE_W-1:0] fsub,
                                                   addr_type src);
      verdict_type v;
      logic        is_beacon;
      int          bit_pos;
      v = '0;
      for (int i = 0; i < learned_count; i++) begin
         if (learned_aps[i] == src) begin
            v.known_source = 1'b1;
         end
      end
      is_beacon = (ftype == BEACON_TYPE) && (fsub == BEACON_SUBTYPE);
      v.accept = 1'b1;
      if (v.known_source && drop_known) begin
         v.accept = 1'b0;
      end else if (!v.known_source && is_beacon) begin
         if (learned_count < DEPTH) begin
            learned_aps[learned_count] = src;
            learned_count++;
            v.learned = 1'b1;
         end else begin
            v.table_full = 1'b1;
         end
         if (drop_known) begin
            v.accept = 1'b0;
         end
      end
      // The 64-bit mask is the high register above the low one, bit type*16+subtype.
      bit_pos = int'(ftype) * 16 + int'(fsub);
      if (v.accept) begin
         v.accept = type_mask[bit_pos];
      end
      return v;
   endfunction

   // Writes one register while the block is idle and mirrors it in the predictor.
   // Called and returns at a falling edge.
   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (index)
         CSR_DROP_KNOWN_AP:  drop_known       = data[0];
         CSR_TYPE_MASK_LOW:  type_mask[31:0]  = data;
         CSR_TYPE_MASK_HIGH: type_mask[63:32] = data;
         default: ;
      endcase
   endtask

   // Sends one header beat, with random idle cycles first. The verdict is predicted at
   // the edge that accepts the beat, so table updates follow the order of acceptance.
   task automatic send_header(logic [TYPE_W-1:0] ftype, logic [SUBTYPE_W-1:0] fsub,
                              addr_type src);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
      end
      req_if.valid          = 1'b1;
      req_if.frame_type     = ftype;
      req_if.frame_subtype  = fsub;
      req_if.source_address = src;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      pending_verdicts.push_back(predict_verdict(ftype, fsub, src));
      n_headers++;
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   // Waits until every predicted verdict has come back, then lets the block settle.
   task automatic wait_drained();
      while (pending_verdicts.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   function automatic addr_type random_address();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Mask values lean toward the extremes so that whole-mask reject and accept both occur.
   function automatic logic [CSR_DATA_W-1:0] random_mask();
      case ($urandom_range(3))
         0:       return '0;
         1:       return TYPE_MASK_RESET;
         default: return $urandom;
      endcase
   endfunction

   // Learning from an empty table: the all-zero and all-one addresses are learned,
   // a repeated beacon is recognized and not stored twice, and non-beacons never learn.
   task automatic test_learning();
      send_header(2'd2, 4'd0, '0);
      send_header(BEACON_TYPE, BEACON_SUBTYPE, '0);
      send_header(BEACON_TYPE, BEACON_SUBTYPE, '0);
      send_header(BEACON_TYPE, BEACON_SUBTYPE, '1);
      send_header(2'd2, 4'd15, '1);
      send_header(2'd3, 4'd15, 48'h5555_AAAA_5555);
      send_header(2'd1, 4'd8, 48'hAAAA_5555_AAAA);
      send_header(BEACON_TYPE, 4'd9, 48'h0000_0000_0001);
   endtask

   // With the drop option set, known sources are rejected and unknown beacons are
   // rejected while still being learned. Unknown non-beacons still see the mask.
   task automatic test_drop_option();
      wait_drained();
      write_register(CSR_DROP_KNOWN_AP, 32'h1);
      send_header(2'd2, 4'd0, '1);
      send_header(BEACON_TYPE, BEACON_SUBTYPE, '0);
      send_header(BEACON_TYPE, BEACON_SUBTYPE, 48'h8000_0000_0000);
      send_header(2'd2, 4'd4, 48'h1234_5678_9ABC);
      send_header(BEACON_TYPE, 4'd5, 48'h8000_0000_0000);
      wait_drained();
      write_register(CSR_DROP_KNOWN_AP, 32'h0);
      send_header(BEACON_TYPE, 4'd5, 48'h8000_0000_0000);
   endtask

   // Each half of the mask cleared in turn, probing the first bit of types 0 and 2 and the last bit of types 1 and 3.
   task automatic test_type_masks();
      wait_drained();
      write_register(CSR_TYPE_MASK_LOW, '0);
      send_header(2'd0, 4'd0, 48'h0102_0304_0506);
      send_header(2'd1, 4'd15, 48'h0102_0304_0506);
      send_header(2'd2, 4'd0, 48'h0102_0304_0506);
      send_header(2'd3, 4'd15, 48'h0102_0304_0506);
      wait_drained();
      write_register(CSR_TYPE_MASK_LOW, TYPE_MASK_RESET);
      write_register(CSR_TYPE_MASK_HIGH, '0);
      send_header(2'd0, 4'd0, '1);
      send_header(2'd1, 4'd15, '1);
      send_header(2'd2, 4'd0, '1);
      send_header(2'd3, 4'd15, '1);
   endtask

   // A write to the index that names no register must leave every register as it was.
   task automatic test_unused_register();
      wait_drained();
      write_register(CSR_UNUSED, 32'h0000_0001);
      send_header(2'd3, 4'd7, '1);
      send_header(2'd1, 4'd2, 48'h0000_0000_0000);
      wait_drained();
      write_register(CSR_TYPE_MASK_HIGH, TYPE_MASK_RESET);
   endtask

   // Random traffic in four idling phases with fresh register settings each time.
   // Sources are mostly learned addresses, one-bit neighbors of them, or new addresses,
   // and beacons are frequent, so the table fills partway through and then stays full.
   task automatic test_random_traffic();
      int               send_idle [4];
      int               rsp_stall [4];
      logic [TYPE_W-1:0]    ftype;
      logic [SUBTYPE_W-1:0] fsub;
      addr_type         src;
      int               pick;
      send_idle = '{0, 81, 0, 23};
      rsp_stall = '{0, 0, 81, 23};
      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         write_register(CSR_DROP_KNOWN_AP, 32'($urandom_range(1)));
         write_register(CSR_TYPE_MASK_LOW, random_mask());
         write_register(CSR_TYPE_MASK_HIGH, random_mask());
         send_idle_pct = send_idle[phase];
         rsp_stall_pct = rsp_stall[phase];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 20) begin
               ftype = BEACON_TYPE;
               fsub  = BEACON_SUBTYPE;
            end else begin
               ftype = TYPE_W'($urandom_range(3));
               fsub  = SUBTYPE_W'($urandom_range(15));
            end
            pick = $urandom_range(99);
            if (learned_count != 0 && pick < 45) begin
               src = learned_aps[$urandom_range(learned_count - 1)];
            end else if (learned_count != 0 && pick < 55) begin
               src = learned_aps[$urandom_range(learned_count - 1)]
                     ^ (48'h1 << $urandom_range(ADDR_W - 1));
            end else begin
               src = random_address();
            end
            send_header(ftype, fsub, src);
         end
      end
   endtask

   // Behavior with every cell filled: new beacons raise table_full with and without
   // the drop option, and known beacons are still recognized.
   task automatic test_full_table();
      wait_drained();
      send_idle_pct = 23;
      rsp_stall_pct = 23;
      write_register(CSR_DROP_KNOWN_AP, 32'h0);
      write_register(CSR_TYPE_MASK_LOW, TYPE_MASK_RESET);
      while (learned_count < DEPTH) begin
         send_header(BEACON_TYPE, BEACON_SUBTYPE, random_address());
      end
      send_header(BEACON_TYPE, BEACON_SUBTYPE, random_address());
      send_header(BEACON_TYPE, BEACON_SUBTYPE, learned_aps[DEPTH - 1]);
      wait_drained();
      write_register(CSR_DROP_KNOWN_AP, 32'h1);
      send_header(BEACON_TYPE, BEACON_SUBTYPE, random_address());
      send_header(BEACON_TYPE, BEACON_SUBTYPE, learned_aps[0]);
      send_header(2'd2, 4'd8, random_address());
   endtask

   // The response side stalls at random; ready changes only at falling edges.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic check_field(string name, logic expected, logic actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, expected,
                  actual);
         errors++;
      end
   endtask

   // Every accepted verdict beat is matched against the oldest prediction.
   always @(posedge clock) begin
      verdict_type expected;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: verdict beat with none expected, actual %0b%0b%0b%0b", $time,
                     rsp_if.accept, rsp_if.known_source, rsp_if.learned, rsp_if.table_full);
            errors++;
         end else begin
            expected = pending_verdicts.pop_front();
            check_field("accept", expected.accept, rsp_if.accept);
            check_field("known_source", expected.known_source, rsp_if.known_source);
            check_field("learned", expected.learned, rsp_if.learned);
            check_field("table_full", expected.table_full, rsp_if.table_full);
            n_verdicts++;
            n_accepted += expected.accept;
            n_known    += expected.known_source;
            n_learned  += expected.learned;
            n_full     += expected.table_full;
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d verdicts outstanding", $time, pending_verdicts.size());
         $display("wifi_frame_filter_ap_learning_unit_tb NOT OK");
         $finish;
      end
   end

   initial begin
      errors        = 0;
      cycles        = 0;
      n_headers     = 0;
      n_verdicts    = 0;
      n_accepted    = 0;
      n_known       = 0;
      n_learned     = 0;
      n_full        = 0;
      learned_count = 0;
      drop_known    = 1'b0;
      type_mask     = {TYPE_MASK_RESET, TYPE_MASK_RESET};
      send_idle_pct = 23;
      rsp_stall_pct = 23;

      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      req_if.valid          = 1'b0;
      req_if.frame_type     = '0;
      req_if.frame_subtype  = '0;
      req_if.source_address = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_learning();
      test_drop_option();
      test_type_masks();
      test_unused_register();
      test_random_traffic();
      test_full_table();

      // Every item yields a verdict, so once the queue is empty only a short settle is left.
      wait_drained();
      repeat (10) @(negedge clock);

      $display("Sent %0d headers and checked %0d verdicts in %0d cycles.", n_headers,
               n_verdicts, cycles);
      $display("Accepted %0d, known source %0d, learned %0d, table full %0d.", n_accepted,
               n_known, n_learned, n_full);
      if (errors == 0) begin
         $display("wifi_frame_filter_ap_learning_unit_tb OK");
      end else begin
         $display("wifi_frame_filter_ap_learning_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
